[hdl/psv_pkg.sv]
`timescale 1ns / 1ps

package psv_pkg;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
  localparam logic [31:0] MAGIC_WORD = 32'h3243474D;

  localparam logic [11:0] POS_STORED = 12'd4;
  localparam logic [11:0] POS_CARD_LEN = 12'd8;
  localparam logic [11:0] POS_FIRST_LEN = 12'd10;
  localparam logic [11:0] POS_SECOND_LEN = 12'd12;
  localparam logic [11:0] POS_RESERVED = 12'd14;
  localparam logic [11:0] HEADER_END = 12'd16;
  localparam logic [11:0] POS_KIND_END = 12'd18;
  localparam logic [11:0] POS_CARD_FLAGS = 12'd24;
  localparam logic [11:0] POS_CARD_PAD = 12'd25;
  localparam logic [11:0] BLOCK_START = 12'd26;
  localparam logic [11:0] BLOCK_STOP = 12'd346;
  localparam logic [11:0] CARD_END = 12'd348;
  localparam logic [11:0] POS_MAX = 12'd4095;

  localparam logic [15:0] CARD_LEN = 16'd332;
  localparam logic [15:0] KIND_MIN = 16'd1000;
  localparam logic [15:0] KIND_MAX = 16'd1002;
  localparam logic [15:0] MIN_SCRIPT = 16'd6;

  localparam logic [5:0] BLOCK_LAST = 6'd39;

  localparam logic [7:0] SCRIPT_OPCODE = 8'hB8;
  localparam logic [7:0] BLOCK_MARKER = 8'hFF;

  localparam logic [2:0] REGION_HEADER = 3'd0;
  localparam logic [2:0] REGION_CARD = 3'd1;
  localparam logic [2:0] REGION_FIRST = 3'd2;
  localparam logic [2:0] REGION_SECOND = 3'd3;
  localparam logic [2:0] REGION_EXCESS = 3'd4;

  typedef struct packed {
    logic [7:0] echo_byte;
    logic [2:0] region;
    logic done_res;
    logic valid_res;
    logic [31:0] parcel_id;
    logic [10:0] first_len;
    logic [10:0] second_len;
  } psv_result_t;

endpackage

[hdl/psv_crc_byte.sv]
`timescale 1ns / 1ps

module psv_crc_byte import psv_pkg::*; (
  input  logic [31:0] crc_in,
  input  logic [7:0]  data_in,
  output logic [31:0] crc_out
);

  always_comb begin
    logic [31:0] c;
    c = crc_in ^ {24'd0, data_in};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    crc_out = c;
  end

endmodule

[hdl/psv_checker.sv]
`timescale 1ns / 1ps

module psv_checker import psv_pkg::*; #(
  parameter int unsigned SCRIPT_LIMIT = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  logic [7:0]  data_byte,
  input  logic        last,
  output psv_result_t result
);

  logic [11:0] pos;
  logic [31:0] crc;
  logic [31:0] stored;
  logic [15:0] card_word;
  logic [15:0] first_word;
  logic [15:0] second_word;
  logic [15:0] kind_word;
  logic        marker;
  logic        failed;
  logic [5:0]  block_off;

  logic [11:0] pos_next;
  logic [31:0] crc_step;
  logic [31:0] crc_next;
  logic [31:0] stored_next;
  logic [15:0] card_word_next;
  logic [15:0] first_word_next;
  logic [15:0] second_word_next;
  logic [15:0] kind_word_next;
  logic        marker_next;
  logic        failed_next;
  logic [5:0]  block_off_next;

  logic [15:0] byte_word;
  logic [15:0] byte_shifted;
  logic        in_block;
  logic        bad;
  logic [17:0] pos_wide;
  logic [17:0] first_end;
  logic [17:0] script_end;
  logic        ok;

  psv_crc_byte u_crc (
    .crc_in  (crc),
    .data_in (data_byte),
    .crc_out (crc_step)
  );

  assign byte_word = {8'd0, data_byte};
  assign byte_shifted = pos[0] ? {data_byte, 8'd0} : byte_word;
  assign in_block = (pos >= BLOCK_START) && (pos < BLOCK_STOP);

  // header and card field capture
  always_comb begin
    stored_next = stored;
    card_word_next = card_word;
    first_word_next = first_word;
    second_word_next = second_word;
    kind_word_next = kind_word;
    bad = 1'b0;
    priority if (pos < POS_STORED) begin
      bad = data_byte != MAGIC_WORD[{pos[1:0], 3'b000} +: 8];
    end else if (pos < POS_CARD_LEN) begin
      stored_next[{pos[1:0], 3'b000} +: 8] = stored[{pos[1:0], 3'b000} +: 8] | data_byte;
    end else if (pos < POS_FIRST_LEN) begin
      card_word_next = card_word | byte_shifted;
    end else if (pos < POS_SECOND_LEN) begin
      first_word_next = first_word | byte_shifted;
    end else if (pos < POS_RESERVED) begin
      second_word_next = second_word | byte_shifted;
    end else if (pos < HEADER_END) begin
      bad = data_byte != 8'd0;
    end else if (pos < POS_KIND_END) begin
      kind_word_next = kind_word | byte_shifted;
    end else if (pos == POS_CARD_FLAGS) begin
      bad = (data_byte[1:0] != 2'd0) || data_byte[5] || (data_byte[7:6] == 2'd3);
    end else if (pos == POS_CARD_PAD) begin
      bad = data_byte != 8'd0;
    end else begin
      bad = 1'b0;
    end
  end

  // marker search over the eight card blocks
  always_comb begin
    marker_next = marker;
    block_off_next = block_off;
    if (in_block) begin
      marker_next = (block_off == 6'd0) ? (data_byte == BLOCK_MARKER)
                                        : (marker || (data_byte == BLOCK_MARKER));
      block_off_next = (block_off == BLOCK_LAST) ? 6'd0 : block_off + 6'd1;
    end
  end

  assign pos_wide = {6'd0, pos};
  assign first_end = {6'd0, CARD_END} + {2'd0, first_word_next};
  assign script_end = first_end + {2'd0, second_word_next};

  always_comb begin
    failed_next = failed || bad
      || (in_block && (block_off == BLOCK_LAST) && !marker_next)
      || ((first_word_next != 16'd0) && (pos == CARD_END) && (data_byte != SCRIPT_OPCODE))
      || ((second_word_next != 16'd0) && (pos >= CARD_END) && (pos_wide == first_end)
          && (data_byte != SCRIPT_OPCODE));
  end

  assign crc_next = (pos >= POS_CARD_LEN) ? crc_step : crc;
  assign pos_next = (pos < POS_MAX) ? pos + 12'd1 : pos;

  always_comb begin
    ok = !failed_next
      && (pos != POS_MAX)
      && (card_word_next == CARD_LEN)
      && (first_word_next <= 16'(SCRIPT_LIMIT))
      && (second_word_next <= 16'(SCRIPT_LIMIT))
      && ((first_word_next != 16'd0) || (second_word_next != 16'd0))
      && ((pos_wide + 18'd1) == script_end)
      && (stored_next == ~crc_next)
      && (kind_word_next >= KIND_MIN) && (kind_word_next <= KIND_MAX)
      && !((kind_word_next == KIND_MAX) && (first_word_next != 16'd0))
      && ((first_word_next == 16'd0) || (first_word_next >= MIN_SCRIPT))
      && ((second_word_next == 16'd0) || (second_word_next >= MIN_SCRIPT));
  end

  always_comb begin
    result.echo_byte = data_byte;
    priority if (pos < HEADER_END) begin
      result.region = REGION_HEADER;
    end else if (pos < CARD_END) begin
      result.region = REGION_CARD;
    end else if (pos_wide < first_end) begin
      result.region = REGION_FIRST;
    end else if (pos_wide < script_end) begin
      result.region = REGION_SECOND;
    end else begin
      result.region = REGION_EXCESS;
    end
    result.done_res = last;
    result.valid_res = last && ok;
    result.parcel_id = (last && ok) ? stored_next : 32'd0;
    result.first_len = (last && ok) ? first_word_next[10:0] : 11'd0;
    result.second_len = (last && ok) ? second_word_next[10:0] : 11'd0;
  end

  // a last word returns everything to the reset state
  always_ff @(posedge clk) begin
    if (rst || (advance && last)) begin
      pos <= 12'd0;
      crc <= CRC_INIT;
      stored <= 32'd0;
      card_word <= 16'd0;
      first_word <= 16'd0;
      second_word <= 16'd0;
      kind_word <= 16'd0;
      marker <= 1'b0;
      failed <= 1'b0;
      block_off <= 6'd0;
    end else if (advance) begin
      pos <= pos_next;
      crc <= crc_next;
      stored <= stored_next;
      card_word <= card_word_next;
      first_word <= first_word_next;
      second_word <= second_word_next;
      kind_word <= kind_word_next;
      marker <= marker_next;
      failed <= failed_next;
      block_off <= block_off_next;
    end
  end

endmodule

[hdl/parcel_stream_validator.sv]
`timescale 1ns / 1ps

// parcel stream validator
// input channel: data_byte and last, one parcel byte per word, handshake
// in_valid / in_ready; last marks the final byte of a parcel
// output channel: one result word per input word, handshake out_valid /
// out_ready; echo_byte and region for every byte, and on the last byte
// done_res with valid_res, parcel_id, first_len and second_len
// a word loads the input register when it is accepted, and its result loads
// the result register once that register can take it
// throughput: one word per cycle while out_ready is high; the byte-wide crc
// update and the position checks sit between the input and result registers
// reset: rst clears both stages and the parcel state; the next byte is taken
// as byte 0 of a new parcel, and so is the byte after any last word
// stall: while out_ready is low the result holds, the input register still
// fills, and in_ready drops once both stages are full

module parcel_stream_validator import psv_pkg::*; #(
  parameter int unsigned SCRIPT_LIMIT = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  echo_byte,
  output logic [2:0]  region,
  output logic        done_res,
  output logic        valid_res,
  output logic [31:0] parcel_id,
  output logic [10:0] first_len,
  output logic [10:0] second_len
);

  logic        stage_valid;
  logic [7:0]  stage_byte;
  logic        stage_last;
  logic        res_ready;
  logic        advance;
  psv_result_t stage_result;
  psv_result_t out_result;

  assign res_ready = !out_valid || out_ready;
  assign in_ready = !stage_valid || res_ready;
  assign advance = stage_valid && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_byte <= data_byte;
      stage_last <= last;
    end
  end

  psv_checker #(
    .SCRIPT_LIMIT (SCRIPT_LIMIT)
  ) u_checker (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .data_byte (stage_byte),
    .last      (stage_last),
    .result    (stage_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= stage_result;
    end
  end

  assign echo_byte = out_result.echo_byte;
  assign region = out_result.region;
  assign done_res = out_result.done_res;
  assign valid_res = out_result.valid_res;
  assign parcel_id = out_result.parcel_id;
  assign first_len = out_result.first_len;
  assign second_len = out_result.second_len;

endmodule
